[rtl/lcd_pkg.sv]
// Package for the lane change detector: field widths, register map,
// fixed-point thresholds and a shared absolute-value helper.
// No dependencies.
package lcd_pkg;

    localparam int OFFSET_W = 16;
    localparam int GRADE_W  = 8;
    localparam int LIMIT_W  = 15;
    localparam int MAG_W    = OFFSET_W + 1;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 4;
    localparam int REG_IDX_W = 2;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_JUMP_WIDTH    = 2'd0;
    localparam t_reg_idx REG_NEAR_LIMIT    = 2'd1;
    localparam t_reg_idx REG_QUALITY_FLOOR = 2'd2;

    localparam logic [LIMIT_W-1:0] JUMP_WIDTH_RST    = 15'd1024;
    localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST    = 15'd1024;
    localparam logic [GRADE_W-1:0] QUALITY_FLOOR_RST = 8'd1;

    // 0.5 m and 1.0 m in units of 1/1024 m.
    localparam logic [MAG_W-1:0] HALF_METER = 17'd512;
    localparam logic [MAG_W-1:0] ONE_METER  = 17'd1024;

    localparam logic [1:0] SETTLE_DONE = 2'd3;

    function automatic logic [MAG_W-1:0] lcd_abs(input logic signed [MAG_W-1:0] v);
        logic signed [MAG_W-1:0] neg;
        neg = -v;
        return v[MAG_W-1] ? neg : v;
    endfunction

endpackage

[rtl/lcd_if.sv]
// Valid/ready channel interfaces for the lane change detector: the input
// frame channel and the result channel. Depends on lcd_pkg.
interface lcd_in_if import lcd_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [OFFSET_W-1:0] left_offset;
    logic        [GRADE_W-1:0]  left_grade;
    logic signed [OFFSET_W-1:0] right_offset;
    logic        [GRADE_W-1:0]  right_grade;

    modport source (output valid, left_offset, left_grade, right_offset, right_grade,
                    input ready);
    modport sink   (input valid, left_offset, left_grade, right_offset, right_grade,
                    output ready);
endinterface

interface lcd_out_if;
    logic valid;
    logic ready;
    logic change_left;
    logic change_right;

    modport source (output valid, change_left, change_right, input ready);
    modport sink   (input valid, change_left, change_right, output ready);
endinterface

[rtl/lane_change_detector.sv]
// Lane change detector top level. A frame word passes through the input
// register, then the phase logic and the result register. Throughput is
// one frame per cycle while the result side is not stalled; the phase,
// settle count and two-frame history update in the cycle a frame leaves
// the input register. Synchronous active-low reset clears the phase, the
// history to zero and the registers to 1024, 1024 and 1.
module lane_change_detector import lcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lcd_in_if.sink             i_in,
    lcd_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_START = 2'd1,
        PH_IN    = 2'd2,
        PH_END   = 2'd3
    } t_phase;

    // Configuration registers.
    logic [LIMIT_W-1:0] r_jump_width;
    logic [LIMIT_W-1:0] r_near_limit;
    logic [GRADE_W-1:0] r_quality_floor;
    t_reg_idx           cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_width    <= JUMP_WIDTH_RST;
            r_near_limit    <= NEAR_LIMIT_RST;
            r_quality_floor <= QUALITY_FLOOR_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_JUMP_WIDTH:    r_jump_width    <= pwdata[LIMIT_W-1:0];
                REG_NEAR_LIMIT:    r_near_limit    <= pwdata[LIMIT_W-1:0];
                REG_QUALITY_FLOOR: r_quality_floor <= pwdata[GRADE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_JUMP_WIDTH:    prdata = {{(PDATA_W-LIMIT_W){1'b0}}, r_jump_width};
            REG_NEAR_LIMIT:    prdata = {{(PDATA_W-LIMIT_W){1'b0}}, r_near_limit};
            REG_QUALITY_FLOOR: prdata = {{(PDATA_W-GRADE_W){1'b0}}, r_quality_floor};
            default:           prdata = '0;
        endcase
    end

    // Input register.
    logic                       r_s1_valid;
    logic signed [OFFSET_W-1:0] r_lo;
    logic        [GRADE_W-1:0]  r_lg;
    logic signed [OFFSET_W-1:0] r_ro;
    logic        [GRADE_W-1:0]  r_rg;
    logic                       s1_adv;
    logic                       in_take;

    // Result register.
    logic r_out_valid;
    logic r_change_left;
    logic r_change_right;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_s1_valid || s1_adv);
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_lo <= i_in.left_offset;
            r_lg <= i_in.left_grade;
            r_ro <= i_in.right_offset;
            r_rg <= i_in.right_grade;
        end
    end

    // History: the previous frame in full, and the grades from two frames back.
    logic signed [OFFSET_W-1:0] r_h0_lo;
    logic signed [OFFSET_W-1:0] r_h0_ro;
    logic        [GRADE_W-1:0]  r_h0_lg;
    logic        [GRADE_W-1:0]  r_h0_rg;
    logic        [GRADE_W-1:0]  r_h1_lg;
    logic        [GRADE_W-1:0]  r_h1_rg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0_lo <= '0;
            r_h0_ro <= '0;
            r_h0_lg <= '0;
            r_h0_rg <= '0;
            r_h1_lg <= '0;
            r_h1_rg <= '0;
        end else if (s1_adv) begin
            r_h1_lg <= r_h0_lg;
            r_h1_rg <= r_h0_rg;
            r_h0_lo <= r_lo;
            r_h0_ro <= r_ro;
            r_h0_lg <= r_lg;
            r_h0_rg <= r_rg;
        end
    end

    // Frame evaluation.
    logic signed [MAG_W-1:0] l_diff;
    logic signed [MAG_W-1:0] r_diff_w;
    logic [MAG_W-1:0] ld, rd, la, ra;
    logic [MAG_W-1:0] jw, nl;
    logic lgood, rgood, good, jump, start;

    assign l_diff   = {r_lo[OFFSET_W-1], r_lo} - {r_h0_lo[OFFSET_W-1], r_h0_lo};
    assign r_diff_w = {r_ro[OFFSET_W-1], r_ro} - {r_h0_ro[OFFSET_W-1], r_h0_ro};
    assign ld = lcd_abs(l_diff);
    assign rd = lcd_abs(r_diff_w);
    assign la = lcd_abs({r_lo[OFFSET_W-1], r_lo});
    assign ra = lcd_abs({r_ro[OFFSET_W-1], r_ro});
    assign jw = {{(MAG_W-LIMIT_W){1'b0}}, r_jump_width};
    assign nl = {{(MAG_W-LIMIT_W){1'b0}}, r_near_limit};

    assign lgood = (r_lg > r_quality_floor) && (r_h1_lg > r_quality_floor);
    assign rgood = (r_rg > r_quality_floor) && (r_h1_rg > r_quality_floor);
    assign good  = lgood || rgood;
    // Every trusted side must have jumped; with no trusted side there is no jump.
    assign jump  = good && (!lgood || (ld > jw)) && (!rgood || (rd > jw));
    assign start = good && ((la < nl) || (ra < nl));

    t_phase     r_phase, n_phase;
    logic [1:0] r_settle, n_settle;
    logic       r_dir_left, n_dir_left;
    logic       r_dir_right, n_dir_right;
    logic       n_change_left, n_change_right;

    always_comb begin
        n_phase        = r_phase;
        n_settle       = r_settle;
        n_change_left  = 1'b0;
        n_change_right = 1'b0;
        unique case (r_phase)
            PH_NONE: begin
                n_settle = '0;
                if (start) begin
                    n_phase = PH_START;
                end
            end
            PH_START: begin
                if (!good || ((la > ONE_METER) && (ra > ONE_METER))) begin
                    n_phase = PH_NONE;
                end else if (jump) begin
                    n_phase        = PH_IN;
                    n_change_left  = r_dir_left;
                    n_change_right = r_dir_right;
                end
            end
            PH_IN: begin
                if (!good) begin
                    n_phase = PH_NONE;
                end else begin
                    if ((ld < HALF_METER) && (rd < HALF_METER)) begin
                        if (r_settle != SETTLE_DONE) begin
                            n_settle = r_settle + 2'd1;
                        end
                    end else begin
                        n_settle = '0;
                    end
                    if (n_settle == SETTLE_DONE) begin
                        n_phase = PH_END;
                    end else begin
                        n_change_left  = r_dir_left;
                        n_change_right = r_dir_right;
                    end
                end
            end
            PH_END: begin
                n_settle = '0;
                n_phase  = PH_NONE;
            end
            default: begin
                n_phase = PH_NONE;
            end
        endcase

        n_dir_left  = r_dir_left;
        n_dir_right = r_dir_right;
        if (n_phase == PH_START) begin
            if (la > ra) begin
                n_dir_right = 1'b1;
            end else begin
                n_dir_left = 1'b1;
            end
        end else if ((n_phase == PH_END) || (n_phase == PH_NONE)) begin
            n_dir_left  = 1'b0;
            n_dir_right = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NONE;
            r_settle    <= '0;
            r_dir_left  <= 1'b0;
            r_dir_right <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_phase        <= n_phase;
                r_settle       <= n_settle;
                r_dir_left     <= n_dir_left;
                r_dir_right    <= n_dir_right;
                r_out_valid    <= 1'b1;
                r_change_left  <= n_change_left;
                r_change_right <= n_change_right;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.change_left  = r_change_left;
    assign o_out.change_right = r_change_right;

endmodule

[rtl/lcd_checker.sv]
// Port-level checker for the lane change detector and its bind statement.
// Depends on lane_change_detector and its channel interfaces.
module lcd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_change_left,
    input logic i_change_right
);

    // A stalled result word holds its flags.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_change_left)
        && $stable(i_change_right))
        else $error("result word changed while stalled");

    // The input side only stalls when the result side is stalled.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while result side is free");

    // A result on an empty output follows its frame word through both registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result word without a frame two cycles earlier");

    // Nothing is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind lane_change_detector lcd_checker u_lcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_change_left  (o_out.change_left),
    .i_change_right (o_out.change_right)
);
